// ===== rtl/core/casf_pkg.sv =====
// ----------------------------------------------------------------------------
// casf_pkg
// Shared types, mode codes and segment helpers for the clock and average
// segment formatter.
// ----------------------------------------------------------------------------
package casf_pkg;

	typedef logic [3:0] mode_t;

	localparam mode_t MODE_TIME      = 4'd0;
	localparam mode_t MODE_DATE      = 4'd1;
	localparam mode_t MODE_EDIT_SEC  = 4'd2;
	localparam mode_t MODE_EDIT_MIN  = 4'd3;
	localparam mode_t MODE_EDIT_HOUR = 4'd4;
	localparam mode_t MODE_EDIT_DAY  = 4'd5;
	localparam mode_t MODE_EDIT_MON  = 4'd6;
	localparam mode_t MODE_EDIT_YEAR = 4'd7;
	localparam mode_t MODE_AVG       = 4'd8;

	localparam logic [7:0] SEP_DOT = 8'h80;

	typedef struct packed {
		mode_t      mode;
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic       blink_on;
	} fields_t;

	typedef struct packed {
		logic acc;
		logic adv1;
		logic adv2;
		logic adv3;
		logic adv4;
	} pipe_ctrl_t;

	typedef logic [5:0][3:0] dec_digits_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	// tens digit of a value below 128: multiply by 205, shift by 11
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

endpackage

// ===== rtl/core/casf_avg.sv =====
// ----------------------------------------------------------------------------
// casf_avg
// Sample ring with running total and mean by reciprocal multiplication.
// ----------------------------------------------------------------------------
module casf_avg #(
	parameter int SAMPLE_COUNT = 128,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  casf_pkg::pipe_ctrl_t    ctrl,
	input  logic [11:0]             sample,
	output logic [SAMPLE_BITS-1:0]  mean_s3
);

	localparam int SLOT_W   = $clog2(SAMPLE_COUNT);
	localparam int TOT_W    = SAMPLE_BITS + SLOT_W;
	localparam int RECIP_SH = TOT_W + SLOT_W;
	localparam int PROD_W   = 2 * TOT_W + 2;
	localparam longint unsigned RECIP = ((64'd1 << RECIP_SH) / SAMPLE_COUNT) + 64'd1;
	localparam longint unsigned TOT_MAX =
		64'(SAMPLE_COUNT) * ((64'd1 << SAMPLE_BITS) - 64'd1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLE_COUNT - 1);

	logic [SAMPLE_BITS-1:0] ring [SAMPLE_COUNT];
	logic [SLOT_W-1:0]      slot_q;
	logic                   filled_q;
	logic [TOT_W-1:0]       total_q;

	logic [SAMPLE_BITS-1:0] smp_s1;
	logic [SAMPLE_BITS-1:0] rd_s1;
	logic [SLOT_W-1:0]      slot_s1;
	logic                   fresh_s1;
	logic [TOT_W-1:0]       total_s2;

	logic [SAMPLE_BITS-1:0] old_smp;
	logic [TOT_W-1:0]       total_nxt;
	logic [PROD_W-1:0]      prod;

	// an entry not yet written since reset reads as zero
	assign old_smp   = fresh_s1 ? '0 : rd_s1;
	assign total_nxt = total_q - TOT_W'(old_smp) + TOT_W'(smp_s1);
	assign prod      = PROD_W'(total_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			smp_s1   <= SAMPLE_BITS'(sample);
			rd_s1    <= ring[slot_q];
			slot_s1  <= slot_q;
			fresh_s1 <= !filled_q;
		end
		if (ctrl.adv1) begin
			ring[slot_s1] <= smp_s1;
			total_s2      <= total_nxt;
		end
		if (ctrl.adv2) begin
			mean_s3 <= SAMPLE_BITS'(prod >> RECIP_SH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			filled_q <= 1'b0;
			total_q  <= '0;
		end else begin
			if (ctrl.acc) begin
				if (slot_q == SLOT_LAST) begin
					slot_q   <= '0;
					filled_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (ctrl.adv1) begin
				total_q <= total_nxt;
			end
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		64'(total_q) <= TOT_MAX)
		else $error("running total beyond ring capacity");

	a_fill_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.acc && slot_q == SLOT_LAST) |=> (filled_q && slot_q == '0))
		else $error("ring wrap not recorded");

endmodule

// ===== rtl/core/casf_dec.sv =====
// ----------------------------------------------------------------------------
// casf_dec
// Decimal split of the mean into six digits by parallel constant divides.
// ----------------------------------------------------------------------------
module casf_dec #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                     clk,
	input  casf_pkg::pipe_ctrl_t     ctrl,
	input  logic [SAMPLE_BITS-1:0]   mean_s3,
	output casf_pkg::dec_digits_t    digits
);

	localparam int MW     = SAMPLE_BITS;
	localparam int PROD_W = 2 * MW + 2;

	logic [MW-1:0] mean_s4;
	logic [MW-1:0] quo [7];

	always_ff @(posedge clk) begin
		if (ctrl.adv3) begin
			mean_s4 <= mean_s3;
		end
	end

	assign quo[0] = mean_s4;
	assign quo[6] = '0;

	for (genvar k = 1; k < 6; k++) begin : g_div
		localparam longint unsigned DIV = 64'(10 ** k);
		localparam int              SH  = MW + $clog2(DIV);
		localparam longint unsigned M   = ((64'd1 << SH) / DIV) + 64'd1;

		logic [PROD_W-1:0] prod;
		logic [MW-1:0]     quo_s4;

		assign prod = PROD_W'(mean_s3) * PROD_W'(M);

		always_ff @(posedge clk) begin
			if (ctrl.adv3) begin
				quo_s4 <= MW'(prod >> SH);
			end
		end

		assign quo[k] = quo_s4;
	end

	for (genvar k = 0; k < 6; k++) begin : g_digit
		assign digits[k] = 4'(quo[k] - MW'(quo[k+1] * MW'(10)));
	end

endmodule

// ===== rtl/core/casf_fmt.sv =====
// ----------------------------------------------------------------------------
// casf_fmt
// Segment formatting by mode, edit blanking, separators and result register.
// ----------------------------------------------------------------------------
module casf_fmt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  casf_pkg::pipe_ctrl_t   ctrl,
	input  casf_pkg::fields_t      f,
	input  casf_pkg::dec_digits_t  digits,
	output logic [7:0]             digit0,
	output logic [7:0]             digit1,
	output logic [7:0]             digit2,
	output logic [7:0]             digit3,
	output logic [7:0]             digit4,
	output logic [7:0]             digit5
);

	typedef logic [1:0][7:0] pair_t;
	typedef logic [5:0][7:0] bytes_t;

	bytes_t seg;
	bytes_t digit_q;

	function automatic pair_t put_field(input logic [6:0] v, input logic lo_dot,
			input logic shown);
		logic [3:0] tens;
		logic [3:0] ones;
		logic [7:0] keep;
		pair_t      p;
		tens = casf_pkg::tens_of(v);
		ones = 4'(v - 7'(tens) * 7'd10);
		keep = shown ? 8'hFF : 8'h00;
		p[0] = (casf_pkg::seg_of(ones) & keep) | (lo_dot ? casf_pkg::SEP_DOT : 8'h00);
		p[1] = casf_pkg::seg_of(tens) & keep;
		return p;
	endfunction

	always_comb begin
		seg = '0;
		case (f.mode)
			casf_pkg::MODE_TIME, casf_pkg::MODE_EDIT_SEC, casf_pkg::MODE_EDIT_MIN,
			casf_pkg::MODE_EDIT_HOUR: begin
				seg[1:0] = put_field(7'(f.seconds), 1'b0,
					f.mode != casf_pkg::MODE_EDIT_SEC || f.blink_on);
				seg[3:2] = put_field(7'(f.minutes), 1'b1,
					f.mode != casf_pkg::MODE_EDIT_MIN || f.blink_on);
				seg[5:4] = put_field(7'(f.hours), 1'b1,
					f.mode != casf_pkg::MODE_EDIT_HOUR || f.blink_on);
			end
			casf_pkg::MODE_DATE, casf_pkg::MODE_EDIT_DAY, casf_pkg::MODE_EDIT_MON,
			casf_pkg::MODE_EDIT_YEAR: begin
				seg[1:0] = put_field(7'(f.day), 1'b0,
					f.mode != casf_pkg::MODE_EDIT_DAY || f.blink_on);
				seg[3:2] = put_field(7'(f.month), 1'b1,
					f.mode != casf_pkg::MODE_EDIT_MON || f.blink_on);
				seg[5:4] = put_field(f.year, 1'b1,
					f.mode != casf_pkg::MODE_EDIT_YEAR || f.blink_on);
			end
			casf_pkg::MODE_AVG: begin
				for (int i = 0; i < 6; i++) begin
					seg[i] = casf_pkg::seg_of(digits[i]);
				end
			end
			default: begin
				seg = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv4) begin
			digit_q <= seg;
		end
	end

	assign digit0 = digit_q[0];
	assign digit1 = digit_q[1];
	assign digit2 = digit_q[2];
	assign digit3 = digit_q[3];
	assign digit4 = digit_q[4];
	assign digit5 = digit_q[5];

	a_blank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.adv4 && f.mode > casf_pkg::MODE_AVG) |=>
		(digit0 == 8'h00 && digit1 == 8'h00 && digit2 == 8'h00 &&
		 digit3 == 8'h00 && digit4 == 8'h00 && digit5 == 8'h00))
		else $error("unknown mode not blanked");

endmodule

// ===== rtl/core/clock_and_average_segment_formatter_top.sv =====
// ----------------------------------------------------------------------------
// clock_and_average_segment_formatter_top
// Six-digit seven-segment formatter for time, date and a running sample mean.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out after passing all five registers,
// and a new transaction is taken every cycle while the output side is ready.
// The pipeline is five registers deep: input, running total, mean, decimal
// split, result. Throughput is set by the sample ring memory, which takes one
// read (at acceptance) and one write (one stage later) per transaction. The
// ring starts empty after reset with no clearing pass: entries not yet written
// count as zero, so early means include them. Stages advance independently,
// so empty stages fill while a result waits to be taken.
module clock_and_average_segment_formatter_top #(
	parameter int SAMPLE_COUNT = 128,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mode,
	input  logic [5:0]  seconds,
	input  logic [5:0]  minutes,
	input  logic [4:0]  hours,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [6:0]  year,
	input  logic [11:0] sample,
	input  logic        blink_on,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  digit0,
	output logic [7:0]  digit1,
	output logic [7:0]  digit2,
	output logic [7:0]  digit3,
	output logic [7:0]  digit4,
	output logic [7:0]  digit5
);

	casf_pkg::pipe_ctrl_t  ctrl;
	casf_pkg::fields_t     f_in;
	casf_pkg::fields_t     f_s1;
	casf_pkg::fields_t     f_s2;
	casf_pkg::fields_t     f_s3;
	casf_pkg::fields_t     f_s4;
	casf_pkg::dec_digits_t digits;
	logic [SAMPLE_BITS-1:0] mean_s3;

	logic v1_q, v2_q, v3_q, v4_q, out_v_q;
	logic en1, en2, en3, en4, out_en;

	// hold a stage only while the one after it is full and holding
	assign out_en = !out_v_q || out_ready;
	assign en4    = !v4_q || out_en;
	assign en3    = !v3_q || en4;
	assign en2    = !v2_q || en3;
	assign en1    = !v1_q || en2;

	assign ctrl.acc  = in_valid && en1;
	assign ctrl.adv1 = v1_q && en2;
	assign ctrl.adv2 = v2_q && en3;
	assign ctrl.adv3 = v3_q && en4;
	assign ctrl.adv4 = v4_q && out_en;

	assign in_ready  = en1;
	assign out_valid = out_v_q;

	assign f_in.mode     = mode;
	assign f_in.seconds  = seconds;
	assign f_in.minutes  = minutes;
	assign f_in.hours    = hours;
	assign f_in.day      = day;
	assign f_in.month    = month;
	assign f_in.year     = year;
	assign f_in.blink_on = blink_on;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= in_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
			if (en4) begin
				v4_q <= v3_q;
			end
			if (out_en) begin
				out_v_q <= v4_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc) begin
			f_s1 <= f_in;
		end
		if (ctrl.adv1) begin
			f_s2 <= f_s1;
		end
		if (ctrl.adv2) begin
			f_s3 <= f_s2;
		end
		if (ctrl.adv3) begin
			f_s4 <= f_s3;
		end
	end

	casf_avg #(
		.SAMPLE_COUNT (SAMPLE_COUNT),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.sample  (sample),
		.mean_s3 (mean_s3)
	);

	casf_dec #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dec (
		.clk     (clk),
		.ctrl    (ctrl),
		.mean_s3 (mean_s3),
		.digits  (digits)
	);

	casf_fmt u_fmt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.f      (f_s4),
		.digits (digits),
		.digit0 (digit0),
		.digit1 (digit1),
		.digit2 (digit2),
		.digit3 (digit3),
		.digit4 (digit4),
		.digit5 (digit5)
	);

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> in_ready)
		else $error("input stalled with result register empty");

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.acc |=> v1_q)
		else $error("accepted transaction lost at input stage");

endmodule
